/* hdl/tsc_pkg.sv */
package tsc_pkg;

   localparam int TILE_W = 10;
   localparam int ID_W   = 16;
   localparam int OP_W   = 2;

   localparam logic [ID_W-1:0]   FREE_ID        = 16'hFFFF;
   localparam logic [TILE_W-1:0] TILE_END_RESET = 10'd1023;

   typedef enum logic [OP_W-1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic encode;
      logic apply;
   } cmd_type;

endpackage

/* hdl/tsc_ctrl.sv */
module tsc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tsc_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_PICK,
      ST_APPLY
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // the result register may be refilled in the cycle it is taken
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.compare = (state_ff == ST_MATCH);
      cmd.encode  = (state_ff == ST_PICK);
      cmd.apply   = (state_ff == ST_APPLY) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new result, or hold one that is not taken yet
         rsp_valid_ff <= ((state_ff == ST_APPLY) && out_free) ||
                         (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_MATCH;
               end
            end
            ST_MATCH: begin
               state_ff <= ST_PICK;
            end
            ST_PICK: begin
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               // hold until the previous result is gone
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* hdl/tsc_datapath.sv */
module tsc_datapath #(
   parameter int SLOTS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tsc_pkg::cmd_type           cmd,
   input  logic [tsc_pkg::OP_W-1:0]   req_op,
   input  logic [tsc_pkg::ID_W-1:0]   req_icon_id,
   input  logic                       csr_we,
   input  logic [tsc_pkg::TILE_W-1:0] csr_wdata,
   output logic [tsc_pkg::TILE_W-1:0] rsp_tile,
   output logic                       rsp_hit,
   output logic                       rsp_load_needed,
   output logic                       rsp_full_res
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SN_W  = $clog2(SLOTS + 1);

   logic [tsc_pkg::ID_W-1:0]   slot_id_ff [SLOTS];
   logic [SLOTS-1:0]           slot_valid_ff;
   logic [tsc_pkg::TILE_W-1:0] tile_end_ff;

   logic [tsc_pkg::OP_W-1:0]   op_ff;
   logic [tsc_pkg::ID_W-1:0]   id_ff;

   logic [SLOTS-1:0]           match_ff, match_in;
   logic                       hit_any_ff, free_any_ff;
   logic [IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in;

   logic [tsc_pkg::TILE_W-1:0] tile_ff, tile_in;
   logic                       hit_ff, hit_in;
   logic                       load_ff, load_in;
   logic                       full_ff, full_in;
   logic                       claim, release_slot, clear_all;

   function automatic logic [tsc_pkg::TILE_W-1:0] slot_tile(
      input logic [tsc_pkg::TILE_W-1:0] tile_end,
      input logic [IDX_W-1:0]           idx
   );
      logic [SN_W-1:0] num;
      num = SN_W'(idx) + SN_W'(1);
      return tile_end - tsc_pkg::TILE_W'({num, 2'b00});
   endfunction

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_in[i] = slot_valid_ff[i] && (slot_id_ff[i] == id_ff);
      end
   end

   // lowest set bit wins
   always_comb begin
      hit_idx_in  = '0;
      free_idx_in = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx_in = IDX_W'(i);
         end
         if (!slot_valid_ff[i]) begin
            free_idx_in = IDX_W'(i);
         end
      end
   end

   always_comb begin
      tile_in      = '0;
      hit_in       = 1'b0;
      load_in      = 1'b0;
      full_in      = 1'b0;
      claim        = 1'b0;
      release_slot = 1'b0;
      clear_all    = 1'b0;
      case (op_ff)
         tsc_pkg::OP_GET: begin
            if (id_ff != tsc_pkg::FREE_ID) begin
               if (hit_any_ff) begin
                  tile_in = slot_tile(tile_end_ff, hit_idx_ff);
                  hit_in  = 1'b1;
               end else if (free_any_ff) begin
                  tile_in = slot_tile(tile_end_ff, free_idx_ff);
                  load_in = 1'b1;
                  claim   = 1'b1;
               end else begin
                  tile_in = tile_end_ff;
                  full_in = 1'b1;
               end
            end
         end
         tsc_pkg::OP_RELEASE: begin
            if (id_ff != tsc_pkg::FREE_ID && hit_any_ff) begin
               hit_in       = 1'b1;
               release_slot = 1'b1;
            end
         end
         tsc_pkg::OP_CLEAR: begin
            clear_all = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_end_ff   <= tsc_pkg::TILE_END_RESET;
         slot_valid_ff <= '0;
      end else begin
         if (csr_we) begin
            tile_end_ff <= csr_wdata;
         end
         if (cmd.apply) begin
            if (clear_all) begin
               slot_valid_ff <= '0;
            end else if (claim) begin
               slot_valid_ff[free_idx_ff] <= 1'b1;
            end else if (release_slot) begin
               slot_valid_ff[hit_idx_ff] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         id_ff <= req_icon_id;
      end
      if (cmd.compare) begin
         match_ff <= match_in;
      end
      if (cmd.encode) begin
         hit_any_ff  <= |match_ff;
         free_any_ff <= ~&slot_valid_ff;
         hit_idx_ff  <= hit_idx_in;
         free_idx_ff <= free_idx_in;
      end
      if (cmd.apply) begin
         if (claim) begin
            slot_id_ff[free_idx_ff] <= id_ff;
         end
         tile_ff <= tile_in;
         hit_ff  <= hit_in;
         load_ff <= load_in;
         full_ff <= full_in;
      end
   end

   assign rsp_tile        = tile_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_load_needed = load_ff;
   assign rsp_full_res    = full_ff;

endmodule

/* hdl/tile_slot_cache.sv */
// Sequence: after the capture edge a request passes the compare, encode and apply
// states; rsp_valid rises at the apply edge, held off while the old result waits.
// Intake: a request is taken only in idle, once the last one has been applied; the
// next item is taken while a finished result still waits in the output register.
// Reset: synchronous, active high; all slots free, tile_end = 1023, no result pending.
module tile_slot_cache #(
   parameter int SLOTS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [tsc_pkg::OP_W-1:0]   req_op,
   input  logic [tsc_pkg::ID_W-1:0]   req_icon_id,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tsc_pkg::TILE_W-1:0] rsp_tile,
   output logic                       rsp_hit,
   output logic                       rsp_load_needed,
   output logic                       rsp_full_res,
   input  logic                       csr_we,
   input  logic [tsc_pkg::TILE_W-1:0] csr_wdata
);

   tsc_pkg::cmd_type cmd;

   tsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   tsc_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_op),
      .req_icon_id     (req_icon_id),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_tile        (rsp_tile),
      .rsp_hit         (rsp_hit),
      .rsp_load_needed (rsp_load_needed),
      .rsp_full_res    (rsp_full_res)
   );

endmodule
